[design/rqsi_pkg.sv]
package rqsi_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int KEY_BITS_DEF    = 16;

  localparam int PID_W    = 8;
  localparam int JOB_W    = 16;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  typedef struct packed {
    logic [PID_W-1:0] pid;
    logic [JOB_W-1:0] len;
    logic [JOB_W-1:0] score;
  } entry_t;

  // insert policies
  localparam logic [1:0] POLICY_FIFO   = 2'd0;
  localparam logic [1:0] POLICY_SORTED = 2'd1;
  localparam logic [1:0] POLICY_PINNED = 2'd2;

  // opcodes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  // register index (paddr[2])
  localparam logic REG_POLICY  = 1'b0;
  localparam logic REG_KEY_SEL = 1'b1;

  // datapath actions
  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_PUSH = 2'd1;
  localparam logic [1:0] ACT_POP  = 2'd2;

  typedef struct packed {
    logic                capture;
    logic                exec;
    logic [1:0]          act;
    logic [STATUS_W-1:0] status;
  } ctl_cmd_t;

  typedef struct packed {
    logic op;
    logic full;
    logic empty;
  } dp_stat_t;

endpackage

[design/rqsi_regs.sv]
module rqsi_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rqsi_pkg::ADDR_W-1:0] paddr,
  input  logic [rqsi_pkg::DATA_W-1:0] pwdata,
  output logic [rqsi_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output logic [1:0]                  insert_policy,
  output logic                        key_select
);
  import rqsi_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      insert_policy <= POLICY_FIFO;
      key_select    <= 1'b0;
    end else if (wr_en) begin
      if (paddr[2] == REG_POLICY) begin
        insert_policy <= pwdata[1:0];
      end else begin
        key_select <= pwdata[0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_KEY_SEL) begin
      prdata[0] = key_select;
    end else begin
      prdata[1:0] = insert_policy;
    end
  end

endmodule

[design/rqsi_ctrl.sv]
module rqsi_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  rqsi_pkg::dp_stat_t stat,
  output rqsi_pkg::ctl_cmd_t cmd,
  output logic               busy,
  output logic               done
);
  import rqsi_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;

  assign busy = (state == S_EXEC);

  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    cmd.act     = ACT_NONE;
    cmd.status  = STATUS_OK;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_IDLE;
        if (stat.op == OP_DEQ) begin
          if (stat.empty) begin
            cmd.status = STATUS_EMPTY;
          end else begin
            cmd.act = ACT_POP;
          end
        end else begin
          if (stat.full) begin
            cmd.status = STATUS_FULL;
          end else begin
            cmd.act = ACT_PUSH;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.exec;
    end
  end

  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_EXEC))
    else $error("result strobe without execute cycle");

  a_exec_one_cycle: assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC |=> state == S_IDLE && done)
    else $error("execute did not complete in one cycle");

  a_accept_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> state == S_IDLE)
    else $error("item captured while busy");

endmodule

[design/rqsi_datapath.sv]
module rqsi_datapath #(
  parameter int QUEUE_DEPTH = rqsi_pkg::QUEUE_DEPTH_DEF,
  parameter int KEY_BITS    = rqsi_pkg::KEY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rqsi_pkg::ctl_cmd_t            cmd,
  output rqsi_pkg::dp_stat_t            stat,
  input  logic [1:0]                    insert_policy,
  input  logic                          key_select,
  input  logic                          opcode,
  input  logic [rqsi_pkg::PID_W-1:0]    process_id,
  input  logic [rqsi_pkg::JOB_W-1:0]    job_length,
  input  logic [rqsi_pkg::JOB_W-1:0]    job_score,
  output logic [rqsi_pkg::STATUS_W-1:0] status,
  output logic                          out_valid,
  output logic [rqsi_pkg::PID_W-1:0]    out_process_id,
  output logic [rqsi_pkg::JOB_W-1:0]    out_length,
  output logic [rqsi_pkg::JOB_W-1:0]    out_score,
  output logic [rqsi_pkg::OCC_W-1:0]    occupancy
);
  import rqsi_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int LV = $clog2(QUEUE_DEPTH);

  entry_t                 slot [QUEUE_DEPTH];
  logic [CW-1:0]          count;
  logic [CW-1:0]          count_next;
  entry_t                 job;
  logic                   op;
  logic                   full;
  logic                   empty;
  logic [QUEUE_DEPTH-1:0] gt_vec;
  logic [QUEUE_DEPTH-1:0] gt;
  logic [QUEUE_DEPTH-1:0] ge_count;
  logic [QUEUE_DEPTH-1:0] ins_mask;
  logic [KEY_BITS-1:0]    new_key;
  logic                   sorted;
  logic                   pinned;

  assign stat.op    = op;
  assign stat.full  = full;
  assign stat.empty = empty;

  assign new_key = key_select ? KEY_BITS'(job_score) : KEY_BITS'(job_length);
  assign sorted  = (insert_policy == POLICY_SORTED) || (insert_policy == POLICY_PINNED);
  assign pinned  = (insert_policy == POLICY_PINNED);

  // per-cell compare against the incoming key
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cmp
    logic [KEY_BITS-1:0] slot_key;
    assign slot_key = key_select ? KEY_BITS'(slot[i].score) : KEY_BITS'(slot[i].len);
    assign gt_vec[i] = (CW'(i) < count) && (slot_key > new_key) && !(pinned && i == 0);
    assign ge_count[i] = (CW'(i) >= count);
  end

  // insert position: first larger key in sorted modes, else tail; mask marks pos and later
  always_comb begin
    logic [QUEUE_DEPTH-1:0] p;
    p = sorted ? gt : '0;
    for (int lvl = 0; lvl < LV; lvl++) begin
      p = p | (p << (1 << lvl));
    end
    ins_mask = p | ge_count;
  end

  always_comb begin
    count_next = count;
    case (cmd.act)
      ACT_PUSH: count_next = count + CW'(1);
      ACT_POP:  count_next = count - CW'(1);
      default:  count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      job.pid   <= process_id;
      job.len   <= job_length;
      job.score <= job_score;
      op        <= opcode;
      full      <= (count >= CW'(QUEUE_DEPTH));
      empty     <= (count == '0);
      gt        <= gt_vec;
    end
  end

  // shifting cell chain
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_slot
    always_ff @(posedge clk) begin
      if (cmd.act == ACT_PUSH && ins_mask[i]) begin
        if (i == 0) begin
          slot[i] <= job;
        end else if (!ins_mask[(i == 0) ? 0 : i-1]) begin
          slot[i] <= job;
        end else begin
          slot[i] <= slot[(i == 0) ? 0 : i-1];
        end
      end else if (cmd.act == ACT_POP && i < QUEUE_DEPTH - 1) begin
        slot[i] <= slot[(i < QUEUE_DEPTH - 1) ? i+1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status    <= cmd.status;
      occupancy <= OCC_W'(count_next);
      if (cmd.act == ACT_POP) begin
        out_valid      <= 1'b1;
        out_process_id <= slot[0].pid;
        out_length     <= slot[0].len;
        out_score      <= slot[0].score;
      end else begin
        out_valid      <= 1'b0;
        out_process_id <= '0;
        out_length     <= '0;
        out_score      <= '0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("entry count above depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    cmd.act == ACT_PUSH |-> count < CW'(QUEUE_DEPTH))
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.act == ACT_POP |-> count != '0)
    else $error("pop from empty queue");

endmodule

[design/ready_queue_sorted_insert_top.sv]
// Ready queue with fifo / sorted / pinned-head insertion over a shifting cell chain.
// A word taken on start is captured, then executed, and its result shows on the done strobe.
// A new word is taken only when idle (capture + compare, then shift of the cell chain).
// busy is high for the one execute cycle and done is a one-cycle strobe; the result
// stays until the next execute and the receiver cannot stall. rst (sync, active high)
// empties the queue and clears the policy and key registers; cells are not cleared.
module ready_queue_sorted_insert_top #(
  parameter int QUEUE_DEPTH = rqsi_pkg::QUEUE_DEPTH_DEF,
  parameter int KEY_BITS    = rqsi_pkg::KEY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // APB-style register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rqsi_pkg::ADDR_W-1:0]   paddr,
  input  logic [rqsi_pkg::DATA_W-1:0]   pwdata,
  output logic [rqsi_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  // command side
  input  logic                          start,
  output logic                          busy,
  input  logic                          opcode,
  input  logic [rqsi_pkg::PID_W-1:0]    process_id,
  input  logic [rqsi_pkg::JOB_W-1:0]    job_length,
  input  logic [rqsi_pkg::JOB_W-1:0]    job_score,
  // result side
  output logic                          done,
  output logic [rqsi_pkg::STATUS_W-1:0] status,
  output logic                          out_valid,
  output logic [rqsi_pkg::PID_W-1:0]    out_process_id,
  output logic [rqsi_pkg::JOB_W-1:0]    out_length,
  output logic [rqsi_pkg::JOB_W-1:0]    out_score,
  output logic [rqsi_pkg::OCC_W-1:0]    occupancy
);
  import rqsi_pkg::*;

  logic       [1:0] insert_policy;
  logic             key_select;
  ctl_cmd_t         cmd;
  dp_stat_t         stat;

  // Register 0 (addr 0): insert policy, 3 behaves as fifo.
  // Register 1 (addr 4): key select, 0 length / 1 score.
  rqsi_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .insert_policy (insert_policy),
    .key_select    (key_select)
  );

  // Controller: idle -> execute -> idle; decides push / pop / reject.
  rqsi_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Datapath: every cell compares its key with the new word at capture;
  // the execute cycle builds the insert mask with a prefix OR and shifts.
  rqsi_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .KEY_BITS    (KEY_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .insert_policy  (insert_policy),
    .key_select     (key_select),
    .opcode         (opcode),
    .process_id     (process_id),
    .job_length     (job_length),
    .job_score      (job_score),
    .status         (status),
    .out_valid      (out_valid),
    .out_process_id (out_process_id),
    .out_length     (out_length),
    .out_score      (out_score),
    .occupancy      (occupancy)
  );

endmodule
